[hdl/rqhs_pkg.sv]
// Shared types and codes for the ring queue with half steal.
// Used by rqhs_ctrl, rqhs_dp and the top level ring_queue_with_half_steal.
package rqhs_pkg;

	localparam int HANDLE_WIDTH = 32;
	localparam int TW           = 7;   // width of take limit, taken count and room

	localparam logic [1:0] MODE_PUSH = 2'd0;
	localparam logic [1:0] MODE_POP  = 2'd1;
	localparam logic [1:0] MODE_GRAB = 2'd2;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_NULL = 2'd2;
	localparam logic [1:0] ST_NONE = 2'd3;

	typedef struct packed {
		logic [1:0]              mode;
		logic [HANDLE_WIDTH-1:0] handle_in;
		logic [TW-1:0]           take_limit;
	} item_t;

	typedef struct packed {
		logic [1:0]              status;
		logic [HANDLE_WIDTH-1:0] handle_out;
		logic [TW-1:0]           taken_total;
		logic [TW-1:0]           room_left;
		logic                    last;
	} result_t;

	// controller to datapath
	typedef struct packed {
		logic latch;      // capture the request
		logic push;       // execute a push and load its result
		logic load_none;  // load a nothing-taken result
		logic start_run;  // advance head, issue first slot read
		logic run;        // run in progress
		logic emit;       // load one taken entry into the result register
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [1:0] mode;
		logic       take_zero;
		logic       slot_free;
		logic       dv;
		logic       last_emit;
	} dp_status_t;

endpackage

[hdl/rqhs_ctrl.sv]
// Controller state machine of the ring queue: sequences accept, execute and run.
// Depends on rqhs_pkg for command and status structs and mode codes.
module rqhs_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  rqhs_pkg::dp_status_t st,
	output rqhs_pkg::dp_cmd_t    cmd
);

	typedef enum logic [1:0] {S_IDLE, S_EXEC, S_RUN} state_t;

	state_t state_q;
	state_t state_d;

	assign req_ready = (state_q == S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.latch = 1'b1;
					state_d   = S_EXEC;
				end
			end
			S_EXEC: begin
				if (st.slot_free) begin
					case (st.mode) inside
						rqhs_pkg::MODE_PUSH: begin
							cmd.push = 1'b1;
							state_d  = S_IDLE;
						end
						rqhs_pkg::MODE_POP, rqhs_pkg::MODE_GRAB: begin
							if (st.take_zero) begin
								cmd.load_none = 1'b1;
								state_d       = S_IDLE;
							end else begin
								cmd.start_run = 1'b1;
								state_d       = S_RUN;
							end
						end
						default: begin
							cmd.load_none = 1'b1;
							state_d       = S_IDLE;
						end
					endcase
				end
			end
			S_RUN: begin
				cmd.run  = 1'b1;
				cmd.emit = st.dv && st.slot_free;
				if (cmd.emit && st.last_emit) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_emit_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> state_q == S_RUN && st.dv)
		else $error("emit outside a run or without read data");

	a_run_ends_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && st.last_emit) |=> state_q == S_IDLE)
		else $error("run did not end after final entry");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !cmd.latch)
		else $error("request captured while busy");

endmodule

[hdl/rqhs_dp.sv]
// Datapath of the ring queue: pointers, slot memory, run counters, result register.
// Depends on rqhs_pkg; driven by commands from rqhs_ctrl.
module rqhs_dp #(
	parameter int CAPACITY = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  rqhs_pkg::item_t        req,
	input  rqhs_pkg::dp_cmd_t      cmd,
	output rqhs_pkg::dp_status_t   st,
	output logic                   rsp_valid,
	input  logic                   rsp_ready,
	output rqhs_pkg::result_t      rsp
);

	localparam int SW = $clog2(CAPACITY);
	localparam int PW = SW + 1;
	localparam int TW = rqhs_pkg::TW;
	localparam int CW = (PW > TW) ? PW : TW;

	logic [rqhs_pkg::HANDLE_WIDTH-1:0] mem [CAPACITY];

	rqhs_pkg::item_t   cmd_q;
	rqhs_pkg::result_t res_q;
	logic              res_valid_q;

	logic [PW-1:0] head_q;
	logic [PW-1:0] tail_q;
	logic [PW-1:0] rd_ptr_q;
	logic [TW-1:0] count_q;
	logic [TW-1:0] reads_left_q;
	logic [TW-1:0] emit_left_q;
	logic [rqhs_pkg::HANDLE_WIDTH-1:0] rdata_q;
	logic          dv_q;

	logic [PW-1:0] used;
	logic [PW-1:0] used_p1;
	logic [PW-1:0] half;
	logic [CW-1:0] half_c;
	logic [CW-1:0] lim_c;
	logic [CW-1:0] count_c;
	logic [TW-1:0] take_cnt;
	logic [TW-1:0] room_cur;
	logic [TW-1:0] room_push;
	logic          is_empty;
	logic          is_full;
	logic          is_null;
	logic          push_ok;
	logic          slot_free;
	logic          rd_en;
	logic [PW-1:0] rd_addr;
	logic [1:0]    push_status;

	assign used     = tail_q - head_q;
	assign is_empty = (used == '0);
	assign is_full  = used[PW-1];
	assign is_null  = (cmd_q.handle_in == '0);
	assign push_ok  = !is_null && !is_full;

	// grab count: ceil(used/2), capped by the request limit
	assign used_p1 = used + PW'(1);
	assign half    = used_p1 >> 1;
	assign half_c  = CW'(half);
	assign lim_c   = CW'(cmd_q.take_limit);
	assign count_c = (half_c < lim_c) ? half_c : lim_c;

	always_comb begin
		if (cmd_q.mode == rqhs_pkg::MODE_POP) begin
			take_cnt = TW'(!is_empty);
		end else begin
			take_cnt = TW'(count_c);
		end
	end

	assign room_cur  = TW'(PW'(CAPACITY) - used);
	assign room_push = push_ok ? room_cur - TW'(1) : room_cur;

	always_comb begin
		if (is_null) begin
			push_status = rqhs_pkg::ST_NULL;
		end else if (is_full) begin
			push_status = rqhs_pkg::ST_FULL;
		end else begin
			push_status = rqhs_pkg::ST_OK;
		end
	end

	assign slot_free = !res_valid_q || rsp_ready;

	// refill the read register only when it is empty or being drained
	assign rd_en   = cmd.start_run ||
	                 (cmd.run && (reads_left_q != '0) && (!dv_q || cmd.emit));
	assign rd_addr = cmd.start_run ? head_q : rd_ptr_q;

	assign st.mode      = cmd_q.mode;
	assign st.take_zero = (take_cnt == '0);
	assign st.slot_free = slot_free;
	assign st.dv        = dv_q;
	assign st.last_emit = (emit_left_q == TW'(1));

	assign rsp_valid = res_valid_q;
	assign rsp       = res_q;

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			cmd_q <= req;
		end
		if (cmd.push && push_ok) begin
			mem[tail_q[SW-1:0]] <= cmd_q.handle_in;
		end
		if (rd_en) begin
			rdata_q  <= mem[rd_addr[SW-1:0]];
			rd_ptr_q <= rd_addr + PW'(1);
		end
		if (cmd.start_run) begin
			count_q <= take_cnt;
		end
		if (cmd.push) begin
			res_q.status      <= push_status;
			res_q.handle_out  <= '0;
			res_q.taken_total <= '0;
			res_q.room_left   <= room_push;
			res_q.last        <= 1'b1;
		end else if (cmd.load_none) begin
			res_q.status      <= rqhs_pkg::ST_NONE;
			res_q.handle_out  <= '0;
			res_q.taken_total <= '0;
			res_q.room_left   <= room_cur;
			res_q.last        <= 1'b1;
		end else if (cmd.emit) begin
			res_q.status      <= rqhs_pkg::ST_OK;
			res_q.handle_out  <= rdata_q;
			res_q.taken_total <= count_q;
			res_q.room_left   <= room_cur;
			res_q.last        <= (emit_left_q == TW'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q       <= '0;
			tail_q       <= '0;
			dv_q         <= 1'b0;
			reads_left_q <= '0;
			emit_left_q  <= '0;
			res_valid_q  <= 1'b0;
		end else begin
			if (cmd.push && push_ok) begin
				tail_q <= tail_q + PW'(1);
			end
			if (cmd.start_run) begin
				head_q       <= head_q + PW'(take_cnt);
				reads_left_q <= take_cnt - TW'(1);
				emit_left_q  <= take_cnt;
			end else begin
				if (rd_en) begin
					reads_left_q <= reads_left_q - TW'(1);
				end
				if (cmd.emit) begin
					emit_left_q <= emit_left_q - TW'(1);
				end
			end
			if (rd_en) begin
				dv_q <= 1'b1;
			end else if (cmd.emit) begin
				dv_q <= 1'b0;
			end
			if (cmd.push || cmd.load_none || cmd.emit) begin
				res_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used <= PW'(CAPACITY))
		else $error("queue holds more than its capacity");

	a_run_balance: assert property (@(posedge clk) disable iff (!arst_n)
		emit_left_q == reads_left_q + TW'(dv_q))
		else $error("run counters out of step with read data");

	a_run_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && emit_left_q == TW'(1)) |=> (emit_left_q == '0 && !dv_q))
		else $error("read data left over after final entry");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.push || cmd.load_none || cmd.emit) |-> slot_free)
		else $error("result register overwritten before transfer");

endmodule

[hdl/ring_queue_with_half_steal.sv]
// Ring queue of task handles with pop-one and grab-half operations.
// Instantiates rqhs_ctrl and rqhs_dp; types and codes come from rqhs_pkg.
//
// Usage:
//   Request channel req_valid/req_ready/req carries one operation: push a handle
//   at the tail, pop one handle from the head, or grab half of the held entries
//   (ceil(n/2), capped by take_limit). Response channel rsp_valid/rsp_ready/rsp
//   carries one result per push, pop or empty grab, and one result per entry of
//   a grab run, the final one marked last.
//   Push and every refused or empty operation load their result in the execute
//   state that follows the request transfer; a pop or grab first reads a slot into
//   the read register, then loads it as a result, and a grab run of k entries goes
//   on at one result a cycle while rsp_ready stays high. One operation is in
//   execution at a time; the next request is taken once the current one has loaded
//   its last result. The single read port of the slot memory paces the grab run.
//   Reset empties the queue at once (head and tail pointers to zero); slot
//   contents are left as they are and need no clearing pass.
//   A stalled receiver holds the result register; a grab run pauses with it and
//   req_ready stays low until the run has drained. A request is still taken
//   while a finished result waits in the result register.
module ring_queue_with_half_steal #(
	parameter int CAPACITY = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  rqhs_pkg::item_t     req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output rqhs_pkg::result_t   rsp
);

	rqhs_pkg::dp_cmd_t    cmd;
	rqhs_pkg::dp_status_t st;

	rqhs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.st        (st),
		.cmd       (cmd)
	);

	rqhs_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.st        (st),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule
